>>> design/bfau_pkg.sv
// Shared types and constants of the bfloat16 arithmetic unit.
// No dependencies; the front end, divider, back end and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package bfau_pkg;

	// Command codes.
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	// Compare codes.
	localparam logic [1:0] CMP_EQ    = 2'd0;
	localparam logic [1:0] CMP_LT    = 2'd1;
	localparam logic [1:0] CMP_GT    = 2'd2;
	localparam logic [1:0] CMP_UNORD = 2'd3;

	// bfloat16 encodings.
	localparam logic [14:0] MAG_INF     = 15'h7F80;
	localparam logic [15:0] QUIET_BIT   = 16'h0040;
	localparam logic [15:0] EXP_MASK    = 16'h7F80;
	localparam logic [15:0] SIGN_BIT    = 16'h8000;
	localparam logic [15:0] DEFAULT_NAN = 16'h7FC0;

	// Internal magnitude width: the value is mag / 2^47 * 2^(exp - 127).
	localparam int MAG_W = 48;
	localparam int EXP_W = 11;

	// Quotient bits produced by the divider.
	localparam int DIV_BITS  = 42;
	localparam int DIV_STEPS = 6;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

	// Record that flows from the front end through the divider to the back end.
	typedef struct packed {
		logic [2:0]              cmd;
		logic                    special;
		logic [15:0]             spec_val;
		logic [1:0]              code;
		logic                    sign;
		logic                    zsign;
		logic signed [EXP_W-1:0] exp;
		logic [MAG_W-1:0]        mag;
		logic [7:0]              rem;
		logic [7:0]              dvd;
		logic [7:0]              dvs;
	} rec_t;

endpackage

`default_nettype wire

>>> design/bfau_front.sv
// Front end: operand decode, special cases, compare, add alignment, multiply.
// Three pipeline stages; depends on bfau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfau_front
	import bfau_pkg::*;
(
	input  wire         clk,
	input  wire  [2:0]  en,
	input  wire  [2:0]  cmd,
	input  wire  [15:0] opa,
	input  wire  [15:0] opb,
	output rec_t        rec_s3
);

	typedef struct packed {
		logic [2:0]              cmd;
		logic                    special;
		logic [15:0]             spec_val;
		logic [1:0]              code;
		logic                    sign;
		logic                    zsign;
		logic signed [EXP_W-1:0] exp;
		logic [7:0]              big_m;
		logic [7:0]              small_m;
		logic [5:0]              shamt;
		logic                    sub;
		logic [15:0]             prod;
		logic [7:0]              dvd;
		logic [7:0]              dvs;
	} s1_t;

	typedef struct packed {
		logic [2:0]              cmd;
		logic                    special;
		logic [15:0]             spec_val;
		logic [1:0]              code;
		logic                    sign;
		logic                    zsign;
		logic signed [EXP_W-1:0] exp;
		logic [MAG_W-1:0]        mag_big;
		logic [MAG_W-1:0]        mag_small;
		logic                    sub;
		logic [7:0]              dvd;
		logic [7:0]              dvs;
	} s2_t;

	s1_t  nx1, st_s1;
	s2_t  nx2, st_s2;
	rec_t nx3;

	logic [14:0] am, bm;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, bs_inf;
	logic [15:0] beff;
	logic [7:0]  ea, eb, ma, mb, big_e, small_e, ediff;
	logic        a_ge, sx;
	logic [63:0] ext;

	// Stage 1: classify, handle special operands, compare, multiply, pick the larger addend.
	always_comb begin
		am     = opa[14:0];
		bm     = opb[14:0];
		a_nan  = am > MAG_INF;
		b_nan  = bm > MAG_INF;
		a_inf  = am == MAG_INF;
		b_inf  = bm == MAG_INF;
		a_zero = am == 15'd0;
		b_zero = bm == 15'd0;
		beff   = (cmd == CMD_SUB) ? (opb ^ SIGN_BIT) : opb;
		bs_inf = b_inf;
		ea     = (opa[14:7] == 8'd0) ? 8'd1 : opa[14:7];
		eb     = (opb[14:7] == 8'd0) ? 8'd1 : opb[14:7];
		ma     = {opa[14:7] != 8'd0, opa[6:0]};
		mb     = {opb[14:7] != 8'd0, opb[6:0]};
		sx     = opa[15] ^ opb[15];
		a_ge   = am >= bm;
		big_e  = a_ge ? ea : eb;
		small_e = a_ge ? eb : ea;
		ediff  = big_e - small_e;

		nx1          = '0;
		nx1.cmd      = cmd;
		nx1.dvd      = ma;
		nx1.dvs      = mb;
		nx1.prod     = 16'(ma) * 16'(mb);
		nx1.big_m    = a_ge ? ma : mb;
		nx1.small_m  = a_ge ? mb : ma;
		nx1.shamt    = (ediff > 8'd48) ? 6'd48 : ediff[5:0];
		nx1.sign     = sx;
		nx1.zsign    = sx;
		nx1.special  = 1'b1;
		nx1.spec_val = 16'h0000;
		nx1.code     = CMP_EQ;

		case (cmd)
			CMD_ADD, CMD_SUB: begin
				nx1.sign  = a_ge ? opa[15] : beff[15];
				nx1.zsign = opa[15] & beff[15];
				nx1.sub   = opa[15] ^ beff[15];
				nx1.exp   = $signed({3'b000, big_e}) + 11'sd1;
			end
			CMD_MUL: begin
				nx1.exp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
			end
			CMD_DIV: begin
				nx1.exp = $signed({3'b000, ea}) - $signed({3'b000, eb}) + 11'sd134;
			end
			default: begin
				nx1.exp = '0;
			end
		endcase

		case (cmd)
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
				nx1.special = 1'b1;
				if (a_nan) begin
					nx1.spec_val = opa | QUIET_BIT;
				end else if (b_nan) begin
					nx1.spec_val = opb | QUIET_BIT;
				end else if (cmd == CMD_MUL) begin
					if ((a_inf && b_zero) || (a_zero && b_inf)) begin
						nx1.spec_val = DEFAULT_NAN;
					end else if (a_inf || b_inf) begin
						nx1.spec_val = {sx, 15'd0} | EXP_MASK;
					end else begin
						nx1.special = 1'b0;
					end
				end else if (cmd == CMD_DIV) begin
					if ((a_inf && b_inf) || (a_zero && b_zero)) begin
						nx1.spec_val = DEFAULT_NAN;
					end else if (b_zero || a_inf) begin
						nx1.spec_val = {sx, 15'd0} | EXP_MASK;
					end else if (b_inf) begin
						nx1.spec_val = {sx, 15'd0};
					end else begin
						nx1.special = 1'b0;
					end
				end else begin
					if (a_inf && bs_inf && (opa[15] != beff[15])) begin
						nx1.spec_val = DEFAULT_NAN;
					end else if (a_inf) begin
						nx1.spec_val = opa;
					end else if (bs_inf) begin
						nx1.spec_val = beff;
					end else begin
						nx1.special = 1'b0;
					end
				end
			end
			CMD_CMP: begin
				if (a_nan || b_nan) begin
					nx1.code = CMP_UNORD;
				end else if (a_zero && b_zero) begin
					nx1.code = CMP_EQ;
				end else if (opa == opb) begin
					nx1.code = CMP_EQ;
				end else if (opa[15] != opb[15]) begin
					nx1.code = opa[15] ? CMP_LT : CMP_GT;
				end else if (opa[15]) begin
					nx1.code = (am > bm) ? CMP_LT : CMP_GT;
				end else begin
					nx1.code = (am > bm) ? CMP_GT : CMP_LT;
				end
			end
			default: begin
				nx1.code = CMP_EQ;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st_s1 <= nx1;
		end
	end

	// Stage 2: align the smaller addend or place the product; lost bits are jammed into the lowest bit.
	always_comb begin
		ext           = {1'b0, st_s1.small_m, 55'd0} >> st_s1.shamt;
		nx2           = '0;
		nx2.cmd       = st_s1.cmd;
		nx2.special   = st_s1.special;
		nx2.spec_val  = st_s1.spec_val;
		nx2.code      = st_s1.code;
		nx2.sign      = st_s1.sign;
		nx2.zsign     = st_s1.zsign;
		nx2.exp       = st_s1.exp;
		nx2.dvd       = st_s1.dvd;
		nx2.dvs       = st_s1.dvs;
		case (st_s1.cmd)
			CMD_ADD, CMD_SUB: begin
				nx2.mag_big   = {1'b0, st_s1.big_m, 39'd0};
				nx2.mag_small = ext[63:16] | {47'd0, |ext[15:0]};
				nx2.sub       = st_s1.sub;
			end
			CMD_MUL: begin
				nx2.mag_big = {st_s1.prod, 32'd0};
			end
			default: begin
				nx2.mag_big = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			st_s2 <= nx2;
		end
	end

	// Stage 3: add or subtract magnitudes.
	always_comb begin
		nx3          = '0;
		nx3.cmd      = st_s2.cmd;
		nx3.special  = st_s2.special;
		nx3.spec_val = st_s2.spec_val;
		nx3.code     = st_s2.code;
		nx3.sign     = st_s2.sign;
		nx3.zsign    = st_s2.zsign;
		nx3.exp      = st_s2.exp;
		nx3.dvd      = st_s2.dvd;
		nx3.dvs      = st_s2.dvs;
		nx3.mag      = st_s2.sub ? (st_s2.mag_big - st_s2.mag_small)
		                         : (st_s2.mag_big + st_s2.mag_small);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rec_s3 <= nx3;
		end
	end

endmodule

`default_nettype wire

>>> design/bfau_divider.sv
// Pipelined restoring divider of the significands, several quotient bits a stage.
// Depends on bfau_pkg; records of other commands pass through unchanged.
`timescale 1ns / 1ps
`default_nettype none

module bfau_divider
	import bfau_pkg::*;
(
	input  wire                   clk,
	input  wire  [DIV_STAGES-1:0] en,
	input  rec_t                  rec_in,
	output rec_t                  rec_out
);

	rec_t st [DIV_STAGES:0];

	assign st[0]   = rec_in;
	assign rec_out = st[DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		rec_t        nxt;
		logic [7:0]  r;
		logic [8:0]  t;
		logic [MAG_W-1:0] q;
		logic [DIV_BITS-1:0] num;

		always_comb begin
			nxt = st[j];
			r   = st[j].rem;
			q   = st[j].mag;
			num = {st[j].dvd, (DIV_BITS - 8)'(0)};
			t   = '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				t = {r, num[DIV_BITS - 1 - (j * DIV_STEPS + i)]};
				if (t >= {1'b0, st[j].dvs}) begin
					t = t - {1'b0, st[j].dvs};
					q = {q[MAG_W-2:0], 1'b1};
				end else begin
					q = {q[MAG_W-2:0], 1'b0};
				end
				r = t[7:0];
			end
			if (st[j].cmd == CMD_DIV) begin
				nxt.rem = r;
				if (j == DIV_STAGES - 1) begin
					// Quotient to the top, remainder folds into a sticky bit.
					nxt.mag = {q[DIV_BITS-1:0], 5'd0, r != 8'd0};
				end else begin
					nxt.mag = q;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				st[j+1] <= nxt;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/bfau_back.sv
// Back end: normalize, round to single precision, narrow to bfloat16.
// Five pipeline stages; depends on bfau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfau_back
	import bfau_pkg::*;
(
	input  wire         clk,
	input  wire  [4:0]  en,
	input  wire         rtz,
	input  rec_t        rec_in,
	output logic [15:0] result_s5,
	output logic [1:0]  code_s5
);

	typedef struct packed {
		logic                    special;
		logic [15:0]             spec_val;
		logic [1:0]              code;
		logic                    sign;
		logic                    zsign;
		logic                    zero;
		logic signed [EXP_W-1:0] exp;
		logic [MAG_W-1:0]        mag;
		logic [5:0]              lz;
	} b1_t;

	typedef struct packed {
		logic                    special;
		logic [15:0]             spec_val;
		logic [1:0]              code;
		logic                    sign;
		logic                    zsign;
		logic                    zero;
		logic signed [EXP_W-1:0] exp;
		logic [MAG_W-1:0]        norm;
	} b2_t;

	typedef struct packed {
		logic        special;
		logic [15:0] spec_val;
		logic [1:0]  code;
		logic        sign;
		logic        zsign;
		logic        zero;
		logic        ovf;
		logic [7:0]  efield;
		logic [22:0] frac;
		logic        guard;
		logic        sticky;
	} b3_t;

	typedef struct packed {
		logic        special;
		logic [15:0] spec_val;
		logic [1:0]  code;
		logic [31:0] f;
	} b4_t;

	b1_t nx1, st_s1;
	b2_t nx2, st_s2;
	b3_t nx3, st_s3;
	b4_t nx4, st_s4;

	logic [5:0]              lz;
	logic signed [EXP_W-1:0] kk;
	logic [5:0]              k;
	logic [2*MAG_W-1:0]      dn;
	logic [MAG_W-1:0]        m;
	logic                    xs;
	logic [30:0]             fmag;
	logic [31:0]             rne;
	logic [15:0]             narrow;

	// Stage 1: leading-zero count.
	always_comb begin
		lz = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (rec_in.mag[i]) begin
				lz = 6'(MAG_W - 1 - i);
			end
		end
		nx1.special  = rec_in.special;
		nx1.spec_val = rec_in.spec_val;
		nx1.code     = rec_in.code;
		nx1.sign     = rec_in.sign;
		nx1.zsign    = rec_in.zsign;
		nx1.zero     = rec_in.mag == '0;
		nx1.exp      = rec_in.exp;
		nx1.mag      = rec_in.mag;
		nx1.lz       = lz;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st_s1 <= nx1;
		end
	end

	// Stage 2: normalize.
	always_comb begin
		nx2.special  = st_s1.special;
		nx2.spec_val = st_s1.spec_val;
		nx2.code     = st_s1.code;
		nx2.sign     = st_s1.sign;
		nx2.zsign    = st_s1.zsign;
		nx2.zero     = st_s1.zero;
		nx2.exp      = st_s1.exp - $signed({5'd0, st_s1.lz});
		nx2.norm     = st_s1.mag << st_s1.lz;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			st_s2 <= nx2;
		end
	end

	// Stage 3: denormalize results below the normal range, extract guard and sticky.
	always_comb begin
		kk = 11'sd1 - st_s2.exp;
		k  = (kk > 11'sd48) ? 6'd48 : kk[5:0];
		dn = '0;
		if (st_s2.exp >= 11'sd1) begin
			m          = st_s2.norm;
			xs         = 1'b0;
			nx3.efield = st_s2.exp[7:0];
		end else begin
			dn         = {st_s2.norm, (MAG_W)'(0)} >> k;
			m          = dn[2*MAG_W-1:MAG_W];
			xs         = |dn[MAG_W-1:0];
			nx3.efield = 8'd0;
		end
		nx3.special  = st_s2.special;
		nx3.spec_val = st_s2.spec_val;
		nx3.code     = st_s2.code;
		nx3.sign     = st_s2.sign;
		nx3.zsign    = st_s2.zsign;
		nx3.zero     = st_s2.zero;
		nx3.ovf      = st_s2.exp > 11'sd254;
		nx3.frac     = m[46:24];
		nx3.guard    = m[23];
		nx3.sticky   = (|m[22:0]) | xs;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			st_s3 <= nx3;
		end
	end

	// Stage 4: round to nearest even in single precision; a carry runs into the exponent.
	always_comb begin
		fmag = {st_s3.efield, st_s3.frac}
		     + 31'(st_s3.guard & (st_s3.sticky | st_s3.frac[0]));
		nx4.special  = st_s3.special;
		nx4.spec_val = st_s3.spec_val;
		nx4.code     = st_s3.code;
		if (st_s3.zero) begin
			nx4.f = {st_s3.zsign, 31'd0};
		end else if (st_s3.ovf) begin
			nx4.f = {st_s3.sign, 8'hFF, 23'd0};
		end else begin
			nx4.f = {st_s3.sign, fmag};
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			st_s4 <= nx4;
		end
	end

	// Stage 5: narrow to bfloat16 and select the special result.
	always_comb begin
		rne = st_s4.f + 32'h0000_7FFF + {31'd0, st_s4.f[16]};
		if (st_s4.f[30:23] == 8'hFF) begin
			narrow = (st_s4.f[22:0] != 23'd0) ? (st_s4.f[31:16] | QUIET_BIT)
			                                   : st_s4.f[31:16];
		end else if (rtz) begin
			narrow = st_s4.f[31:16];
		end else begin
			narrow = rne[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			result_s5 <= st_s4.special ? st_s4.spec_val : narrow;
			code_s5   <= st_s4.code;
		end
	end

endmodule

`default_nettype wire

>>> design/bf16_arithmetic_unit.sv
// Top level of the bfloat16 arithmetic unit: handshake, stage valid bits, rounding register.
// Depends on bfau_pkg, bfau_front, bfau_divider and bfau_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each request on the slave stream carries a command (add, subtract, multiply,
// divide or compare) and two bfloat16 operands. Every request gives exactly
// one result on the master stream, in order: the bfloat16 result for the
// arithmetic commands and a compare code for compare.
// The unit is a 15-stage pipeline: three front-end stages, seven divider
// stages that produce six quotient bits each, and five stages that normalize,
// round and narrow. A request passes through the front-end, divider and
// back-end stages in order before it is valid on the master side, and one
// request is accepted every cycle when nothing stalls.
// Each stage has its own valid bit and moves forward when the stage after it
// is empty or moving, so empty stages fill while the receiver stalls and
// s_tready only falls once every stage holds a request. A stalled result
// holds on m_tdata until taken.
// The rounding register is written on the cfg channel, which is always ready;
// write it only while the unit is empty. Reset empties the pipeline and
// selects round to nearest even.

module bf16_arithmetic_unit
	import bfau_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // command [2:0], operand_a [18:3], operand_b [34:19]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // result [15:0], compare_code [17:16]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data   // round_toward_zero
);

	localparam int FRONT_N = 3;
	localparam int BACK_N  = 5;
	localparam int NS      = FRONT_N + DIV_STAGES + BACK_N;

	logic [NS:1] vld_q;
	logic [NS:1] en;
	logic        rtz_q;
	rec_t        front_rec, div_rec;
	logic [15:0] result_s15;
	logic [1:0]  code_s15;

	// A stage may load when it is empty or its content moves on.
	always_comb begin
		en[NS] = !vld_q[NS] || m_tready;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtz_q <= 1'b0;
		end else if (cfg_valid) begin
			rtz_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = en[1];
	assign m_tvalid  = vld_q[NS];
	assign m_tdata   = {6'd0, code_s15, result_s15};

	bfau_front u_front (
		.clk    (clk),
		.en     (en[FRONT_N:1]),
		.cmd    (s_tdata[2:0]),
		.opa    (s_tdata[18:3]),
		.opb    (s_tdata[34:19]),
		.rec_s3 (front_rec)
	);

	bfau_divider u_div (
		.clk     (clk),
		.en      (en[FRONT_N+DIV_STAGES:FRONT_N+1]),
		.rec_in  (front_rec),
		.rec_out (div_rec)
	);

	bfau_back u_back (
		.clk       (clk),
		.en        (en[NS:FRONT_N+DIV_STAGES+1]),
		.rtz       (rtz_q),
		.rec_in    (div_rec),
		.result_s5 (result_s15),
		.code_s5   (code_s15)
	);

endmodule

`default_nettype wire

>>> design/bfau_checker.sv
// Port-level checks of the bfloat16 arithmetic unit, bound to its top level.
// Depends only on the ports of bf16_arithmetic_unit.
`timescale 1ns / 1ps
`default_nettype none

module bfau_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// An empty or draining last stage lets the whole pipeline advance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while the output side moves");

	// A nonzero compare code comes with a zero result field.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:16] != 2'd0) |-> m_tdata[15:0] == 16'd0)
		else $error("compare code with nonzero result");

	// Every NaN delivered is quiet.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[14:7] == 8'hFF) && (m_tdata[6:0] != 7'd0) |-> m_tdata[6])
		else $error("signaling NaN delivered");

endmodule

bind bf16_arithmetic_unit bfau_checker u_bfau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
